// ----- hw/rtl/rdc_pkg.sv -----
package rdc_pkg;

    localparam int VALUE_BITS    = 31;
    localparam int RADIX_BITS    = 5;
    localparam int DIGIT_BITS    = 4;
    localparam int CHAR_BITS     = 7;
    localparam int STEP_BITS     = 8;
    localparam int DIV_STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS      = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CNT_BITS      = $clog2(VALUE_BITS + 1);
    localparam int ADDR_BITS     = $clog2(VALUE_BITS);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);
    localparam logic [DIGIT_BITS-1:0] TEN       = DIGIT_BITS'(10);
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0]  CHAR_NINE = CHAR_BITS'(57);
    localparam logic [CHAR_BITS-1:0]  CHAR_A    = CHAR_BITS'(65);
    localparam logic [CHAR_BITS-1:0]  CHAR_F    = CHAR_BITS'(70);

    typedef struct packed {
        logic load;
        logic div_step;
        logic fetch;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_last;
    } t_status;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < TEN) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            c = CHAR_A + CHAR_BITS'(d - TEN);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/rdc_ram.sv -----
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rdc_dpath.sv -----
module rdc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rdc_pkg::t_cmd                       i_cmd,
    output rdc_pkg::t_status                    o_status,
    input  logic [rdc_pkg::VALUE_BITS-1:0]      i_value,
    input  logic [rdc_pkg::RADIX_BITS-1:0]      i_radix,
    output logic [rdc_pkg::CHAR_BITS-1:0]       o_digit_char,
    output logic                                o_last_digit
);

    import rdc_pkg::*;

    logic [DIV_BITS-1:0]      r_quot, n_quot;
    logic [DIGIT_BITS-1:0]    r_rem, n_rem;
    logic [RADIX_BITS-1:0]    r_radix, n_radix;
    logic [STEP_CNT_BITS-1:0] r_step, n_step;
    logic [CNT_BITS-1:0]      r_cnt, n_cnt;
    logic [CHAR_BITS-1:0]     r_char, n_char;
    logic                     r_last, n_last;

    logic [RADIX_BITS-1:0]    radix_clamped;
    logic [STEP_BITS-1:0]     chunk;
    logic [STEP_BITS-1:0]     qbits;
    logic [DIGIT_BITS:0]      trial;
    logic [DIGIT_BITS-1:0]    rem_next;
    logic [DIV_BITS-1:0]      quot_next;
    logic                     step_last;
    logic [CNT_BITS-1:0]      cnt_inc;
    logic [CNT_BITS-1:0]      cnt_dec;
    logic                     ram_we;
    logic [DIGIT_BITS-1:0]    ram_rdata;

    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        chunk    = r_quot[DIV_BITS-1 -: STEP_BITS];
        rem_next = r_rem;
        qbits    = '0;
        trial    = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem_next, chunk[i]};
            if (trial >= r_radix) begin
                rem_next = DIGIT_BITS'(trial - r_radix);
                qbits[i] = 1'b1;
            end else begin
                rem_next = trial[DIGIT_BITS-1:0];
            end
        end
        quot_next = (r_quot << STEP_BITS) | DIV_BITS'(qbits);
    end

    assign step_last = (r_step == STEP_CNT_BITS'(DIV_STEPS - 1));
    assign cnt_inc   = r_cnt + CNT_BITS'(1);
    assign cnt_dec   = r_cnt - CNT_BITS'(1);
    assign ram_we    = i_cmd.div_step && step_last;

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_char  = r_char;
        n_last  = r_last;
        if (i_cmd.load) begin
            n_quot  = DIV_BITS'(i_value);
            n_rem   = '0;
            n_radix = radix_clamped;
            n_step  = '0;
            n_cnt   = '0;
        end
        if (i_cmd.div_step) begin
            n_quot = quot_next;
            if (step_last) begin
                n_rem  = '0;
                n_step = '0;
                n_cnt  = cnt_inc;
            end else begin
                n_rem  = rem_next;
                n_step = r_step + STEP_CNT_BITS'(1);
            end
        end
        if (i_cmd.fetch) begin
            n_cnt = cnt_dec;
        end
        if (i_cmd.capture) begin
            n_char = digit_to_ascii(ram_rdata);
            n_last = (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot <= '0;
            r_step <= '0;
            r_cnt  <= '0;
        end else begin
            r_quot <= n_quot;
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    rdc_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_BITS-1:0]),
        .i_wdata (rem_next),
        .i_re    (i_cmd.fetch),
        .i_raddr (cnt_dec[ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_status.div_done = step_last &&
                               ((quot_next == '0) || (cnt_inc == CNT_BITS'(VALUE_BITS)));
    assign o_status.out_last = r_last;
    assign o_digit_char      = r_char;
    assign o_last_digit      = r_last;

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (RADIX_BITS'(r_rem) < r_radix))
        else $error("remainder not below radix");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(VALUE_BITS))
        else $error("digit count beyond stack depth");
`endif

endmodule

// ----- hw/rtl/rdc_ctrl.sv -----
module rdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rdc_pkg::t_cmd    o_cmd,
    input  rdc_pkg::t_status i_status
);

    import rdc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_FETCH = 5'b00100,
        S_LOAD  = 5'b01000,
        S_SHOW  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.capture = 1'b1;
                n_state       = S_SHOW;
            end
            S_SHOW: begin
                if (!i_out_stall) begin
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.fetch = 1'b1;
                        n_state     = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_SHOW);

endmodule

// ----- hw/rtl/radix_digit_converter_core.sv -----
// A value yields d digits (d <= 31), each found by a run of divider steps,
// the divider retiring 8 quotient bits a cycle.
// Each further digit is read from the registered stack, then captured for output.
// A new item is taken only once the last digit of the previous one has been output.
// Reset: synchronous, active low; clears the controller, step counter, digit count and quotient.
// The digit stack is not cleared and needs no clearing pass.
module radix_digit_converter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rdc_pkg::VALUE_BITS-1:0]    i_value,
    input  logic [rdc_pkg::RADIX_BITS-1:0]    i_radix,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rdc_pkg::CHAR_BITS-1:0]     o_digit_char,
    output logic                              o_last_digit
);

    import rdc_pkg::*;

    t_cmd    cmd;
    t_status status;

    rdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rdc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

`ifndef SYNTHESIS
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_digit_char >= CHAR_ZERO && o_digit_char <= CHAR_NINE) ||
                         (o_digit_char >= CHAR_A && o_digit_char <= CHAR_F)))
        else $error("digit character out of range");

    a_idle_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output valid while ready for a new item");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_digit) |=> (!o_out_valid && !o_in_stall))
        else $error("item did not end after last digit");
`endif

endmodule

// ----- tb/radix_digit_converter_core_tb.sv -----
module radix_digit_converter_core_tb;

    import rdc_pkg::*;

    localparam int RANDOM_ITEMS    = 232;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_ITEMS  = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 200;
    localparam int REPORT_LIMIT    = 40;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } t_digit;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [VALUE_BITS-1:0] i_value     = '0;
    logic [RADIX_BITS-1:0] i_radix     = RADIX_MIN;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [CHAR_BITS-1:0]  o_digit_char;
    logic                  o_last_digit;

    t_digit                pending_digits[$];
    logic [VALUE_BITS-1:0] dir_value[$];
    logic [RADIX_BITS-1:0] dir_radix[$];
    string                 dir_text[$];
    int                    mismatches    = 0;
    int                    digits_seen   = 0;
    int                    values_sent   = 0;
    bit                    hold_off_req  = 1'b0;

    radix_digit_converter_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

    // Digit string of v in radix r, most significant first; radix clamped to 2..16
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                           input logic [RADIX_BITS-1:0] r);
        logic [DIGIT_BITS-1:0] stack[VALUE_BITS];
        logic [VALUE_BITS-1:0] quot;
        int                    base;
        int                    n;
        t_digit                d;
        base = (r < RADIX_MIN) ? int'(RADIX_MIN) : (r > RADIX_MAX) ? int'(RADIX_MAX) : int'(r);
        quot = v;
        n    = 0;
        if (quot == '0) begin
            d.ch   = CHAR_ZERO;
            d.last = 1'b1;
            pending_digits.push_back(d);
            return;
        end
        while (quot != '0) begin
            stack[n] = DIGIT_BITS'(quot % base);
            quot     = VALUE_BITS'(quot / base);
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            d.ch   = (stack[i] < TEN) ? CHAR_ZERO + CHAR_BITS'(stack[i])
                                      : CHAR_A + CHAR_BITS'(stack[i] - TEN);
            d.last = (i == 0);
            pending_digits.push_back(d);
        end
    endfunction

    function automatic void push_digit_string(input string s);
        t_digit d;
        for (int i = 0; i < s.len(); i++) begin
            d.ch   = CHAR_BITS'(s[i]);
            d.last = (i == s.len() - 1);
            pending_digits.push_back(d);
        end
    endfunction

    task automatic add_row(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] r,
                           input string s);
        dir_value.push_back(v);
        dir_radix.push_back(r);
        dir_text.push_back(s);
    endtask

    // Offer one value; an empty text means the predictor supplies the digits
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] r,
                               input int gap, input string text);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_radix    <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (text.len() != 0) begin
            push_digit_string(text);
        end else begin
            predict_digits(v, r);
        end
        values_sent++;
    endtask

    // Receiver: random stall stretches, one long hold-off on request
    initial begin
        int pick;
        int len;
        bit served;
        served = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !served) begin
                served = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(1, 4);
                end else if (pick < 55) begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(20, 80);
                end else if (pick < 90) begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(15, 60);
                end
                repeat (len) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected transaction, char %0d last %0b",
                             $time, o_digit_char, o_last_digit);
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.ch || o_last_digit !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: digit %0d expected char %0d last %0b, got char %0d last %0b",
                                 $time, digits_seen, want.ch, want.last,
                                 o_digit_char, o_last_digit);
                end
            end
        end
    end

    initial begin
        int                    pick;
        int                    gap;
        int                    k;
        int                    base;
        longint                p;
        logic [VALUE_BITS-1:0] v;
        logic [RADIX_BITS-1:0] r;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(31'd0,          5'd10, "0");
        add_row(31'd0,          5'd2,  "0");
        add_row(31'd1,          5'd2,  "1");
        add_row(31'h7FFFFFFF,   5'd2,  "1111111111111111111111111111111");
        add_row(31'h7FFFFFFF,   5'd16, "7FFFFFFF");
        add_row(31'h7FFFFFFF,   5'd10, "2147483647");
        add_row(31'h7FFFFFFF,   5'd8,  "17777777777");
        add_row(31'd12,         5'd16, "C");
        add_row(31'hABCDEF,     5'd16, "ABCDEF");
        add_row(31'd255,        5'd16, "FF");
        add_row(31'd15,         5'd0,  "1111");
        add_row(31'd5,          5'd1,  "101");
        add_row(31'd255,        5'd17, "FF");
        add_row(31'd255,        5'd31, "FF");
        add_row(31'd10,         5'd10, "10");
        add_row(31'd9,          5'd10, "9");
        add_row(31'h40000000,   5'd2,  "1000000000000000000000000000000");
        add_row(31'd35,         5'd3,  "");
        add_row(31'd1234567,    5'd7,  "");
        add_row(31'd999,        5'd13, "");
        add_row(31'h55555555,   5'd4,  "");
        add_row(31'h2AAAAAAA,   5'd11, "");
        add_row(31'd7777777,    5'd12, "");
        add_row(31'd100000,     5'd14, "");
        add_row(31'd424242,     5'd15, "");
        add_row(31'd88888,      5'd9,  "");
        add_row(31'd31415,      5'd5,  "");
        add_row(31'd271828,     5'd6,  "");

        for (int i = 0; i < dir_value.size(); i++)
            offer_value(dir_value[i], dir_radix[i], $urandom_range(0, 2), dir_text[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            r    = (pick < 85) ? RADIX_BITS'($urandom_range(2, 16))
                               : RADIX_BITS'($urandom_range(0, 31));
            base = (r < RADIX_MIN) ? int'(RADIX_MIN) : (r > RADIX_MAX) ? int'(RADIX_MAX) : int'(r);

            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                v = VALUE_BITS'($urandom());
            end else if (pick < 60) begin
                v = VALUE_BITS'($urandom_range(0, 300));
            end else if (pick < 75) begin
                v = VALUE_BITS'($urandom() >> $urandom_range(1, 31));
            end else if (pick < 85) begin
                // radix powers and one below them
                k = $urandom_range(1, 31);
                p = 1;
                for (int j = 0; j < k; j++)
                    if (p * base <= longint'(31'h7FFFFFFF)) p = p * base;
                v = VALUE_BITS'(p - longint'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                v = ~VALUE_BITS'($urandom_range(0, 255));
            end else begin
                v = '0;
            end

            pick = $urandom_range(0, 99);
            gap  = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (i == HOLD_OFF_AT) hold_off_req = 1'b1;
            if (i >= HOLD_OFF_AT && i < HOLD_OFF_AT + HOLD_OFF_ITEMS) gap = 0;
            offer_value(v, r, gap, "");
        end
        i_in_valid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_digits.size() != 0) mismatches++;

        $display("Converted %0d values (%0d from the directed table), %0d digits checked,",
                 values_sent, dir_value.size(), digits_seen);
        $display("radix codes 0 to 31, values up to full width, one long output hold-off.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
